### sv/s2a_pkg.sv
// s2a_pkg: shared types, key codes, the lookup table and the shifted symbol function for the set 1 scan code decoder
`timescale 1ns / 1ps

package s2a_pkg;

  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [7:0] CODE_CAPS  = 8'h3A;
  localparam int unsigned TABLE_LEN = 84;
  localparam logic [6:0] CASE_GAP   = 7'h20;
  localparam logic [6:0] CHAR_LOW_A = 7'h61;
  localparam logic [6:0] CHAR_LOW_Z = 7'h7A;

  typedef logic [6:0] ascii_t;

  // flag changes requested by one scan byte
  typedef struct packed {
    logic set_left;
    logic set_right;
    logic held_val;
    logic toggle_caps;
  } key_upd_t;

  typedef struct packed {
    logic shift;
    logic caps;
  } key_flags_t;

  // us layout, unshifted, indexed by make code
  localparam ascii_t US_TABLE [0:TABLE_LEN-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E
  };

  function automatic ascii_t shifted_symbol(input ascii_t ch);
    ascii_t res;
    case (ch)
      7'h31:   res = 7'h21;
      7'h32:   res = 7'h40;
      7'h33:   res = 7'h23;
      7'h34:   res = 7'h24;
      7'h35:   res = 7'h25;
      7'h36:   res = 7'h5E;
      7'h37:   res = 7'h26;
      7'h38:   res = 7'h2A;
      7'h39:   res = 7'h28;
      7'h30:   res = 7'h29;
      7'h2D:   res = 7'h5F;
      7'h3D:   res = 7'h2B;
      7'h5B:   res = 7'h7B;
      7'h5D:   res = 7'h7D;
      7'h5C:   res = 7'h7C;
      7'h3B:   res = 7'h3A;
      7'h27:   res = 7'h22;
      7'h60:   res = 7'h7E;
      7'h2C:   res = 7'h3C;
      7'h2E:   res = 7'h3E;
      7'h2F:   res = 7'h3F;
      default: res = ch;
    endcase
    return res;
  endfunction

endpackage

### sv/s2a_decode.sv
// s2a_decode: translates one registered scan byte into a character and flag updates
`timescale 1ns / 1ps

module s2a_decode
  import s2a_pkg::*;
(
  input  logic [7:0] code,
  input  key_flags_t flags,
  output key_upd_t   upd,
  output logic       emit,
  output ascii_t     ch
);

  logic [6:0] key;
  logic       release_bit;
  logic       in_table;
  ascii_t     base;

  assign key         = code[6:0];
  assign release_bit = code[7];
  assign in_table    = (code < 8'(TABLE_LEN));
  assign base        = in_table ? US_TABLE[key] : '0;

  always_comb begin
    upd  = '0;
    emit = 1'b0;
    ch   = base;
    if (key == KEY_LSHIFT) begin
      upd.set_left = 1'b1;
      upd.held_val = !release_bit;
    end else if (key == KEY_RSHIFT) begin
      upd.set_right = 1'b1;
      upd.held_val  = !release_bit;
    end else if (release_bit) begin
      // break codes and the e0 prefix fall out here
    end else if (code == CODE_CAPS) begin
      upd.toggle_caps = 1'b1;
    end else begin
      if (base >= CHAR_LOW_A && base <= CHAR_LOW_Z) begin
        if (flags.caps != flags.shift) begin
          ch = base - CASE_GAP;
        end
      end else if (flags.shift) begin
        ch = shifted_symbol(base);
      end
      emit = (ch != '0);
    end
  end

endmodule

### sv/s2a_key_state.sv
// s2a_key_state: left shift, right shift and caps lock flags
`timescale 1ns / 1ps

module s2a_key_state
  import s2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd_en,
  input  key_upd_t   upd,
  output key_flags_t flags
);

  logic lshift_r, lshift_nxt;
  logic rshift_r, rshift_nxt;
  logic caps_r, caps_nxt;

  always_comb begin
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    caps_nxt   = caps_r;
    if (upd_en) begin
      if (upd.set_left) begin
        lshift_nxt = upd.held_val;
      end
      if (upd.set_right) begin
        rshift_nxt = upd.held_val;
      end
      if (upd.toggle_caps) begin
        caps_nxt = !caps_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      caps_r   <= 1'b0;
    end else begin
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      caps_r   <= caps_nxt;
    end
  end

  assign flags.shift = lshift_r || rshift_r;
  assign flags.caps  = caps_r;

endmodule

### sv/scancode_set1_to_ascii_unit.sv
// scancode_set1_to_ascii_unit: top level of the set 1 scan code to ascii decoder
`timescale 1ns / 1ps

// Takes one raw set 1 scan byte per transfer and gives at most one US-layout
// ascii character per byte. A byte sits in the input register, where the
// table lookup and the shift/caps flag update happen, and a non-nul result
// moves into the output register. One byte per cycle is sustained while the
// output side does not stall. A character passes through the input register
// and then the output register before its output transfer.
// Bytes that give no character (releases, prefixes, shift and caps keys,
// keys without a character) leave the input register without waiting on the
// output side. in_stall rises only when the input register holds a
// character-bearing byte and the output register is full and stalled.
module scancode_set1_to_ascii_unit
  import s2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_ascii_char
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_code_r, s1_code_nxt;
  logic       out_valid_r, out_valid_nxt;
  ascii_t     out_char_r, out_char_nxt;

  key_upd_t   upd;
  key_flags_t flags;
  logic       dec_emit;
  ascii_t     dec_ch;
  logic       s1_fire;
  logic       in_xfer;

  s2a_decode u_decode (
    .code  (s1_code_r),
    .flags (flags),
    .upd   (upd),
    .emit  (dec_emit),
    .ch    (dec_ch)
  );

  s2a_key_state u_key_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_fire),
    .upd    (upd),
    .flags  (flags)
  );

  // a byte leaves the input register if it needs no output slot or one is free
  assign s1_fire  = s1_valid_r && (!dec_emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_code_nxt  = s1_code_r;
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      s1_code_nxt  = in_scan_code;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_fire && dec_emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = dec_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_code_r  <= s1_code_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;

  // an emitted character is never nul
  a_nonzero_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ascii_char != '0)
    else $error("nul character presented on output");

  // a held byte stays put until it can move on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_code_r))
    else $error("input register lost a byte");

  // caps lock only changes on a caps make code leaving the input register
  a_caps_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_fire && s1_code_r == CODE_CAPS) |=> $stable(flags.caps))
    else $error("caps lock changed without a caps make code");

  // a byte that needs an output slot lands in the output register when it moves on
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && dec_emit |=> out_valid && out_ascii_char == $past(dec_ch))
    else $error("character did not reach the output register");

endmodule

### tb/scancode_set1_to_ascii_unit_tb.sv
// scancode_set1_to_ascii_unit_tb: self-checking bench for the set 1 scan code to ascii decoder
`timescale 1ns / 1ps

module scancode_set1_to_ascii_unit_tb;
  import s2a_pkg::*;

  localparam logic [7:0] BREAK_BIT     = 8'h80;
  localparam logic [7:0] EXT_PREFIX    = 8'hE0;
  localparam logic [7:0] LETTER_GAP    = 8'h20;
  localparam int         RANDOM_MAKES  = 540;
  localparam int         TAIL_LEN      = 200;
  localparam int         HOLD_AT       = 400;
  localparam int         LONG_HOLD     = 80;
  localparam int         DRAIN_CYCLES  = 8;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         MAX_REPORTS   = 10;

  // us layout, unshifted, by make code
  localparam logic [7:0] KEYMAP [0:83] = '{
    8'h00, 8'h1B, "1",   "2",   "3",   "4",   "5",   "6",
    "7",   "8",   "9",   "0",   "-",   "=",   8'h08, "\t",
    "q",   "w",   "e",   "r",   "t",   "y",   "u",   "i",
    "o",   "p",   "[",   "]",   8'h0D, 8'h00, "a",   "s",
    "d",   "f",   "g",   "h",   "j",   "k",   "l",   ";",
    8'h27, 8'h60, 8'h00, "\\",  "z",   "x",   "c",   "v",
    "b",   "n",   "m",   ",",   ".",   "/",   8'h00, "*",
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "7",
    "8",   "9",   "-",   "4",   "5",   "6",   "+",   "1",
    "2",   "3",   "0",   "."
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_scan_code = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_ascii_char;

  logic [7:0] pending_codes [$];
  ascii_t     expected_chars [$];

  logic lshift_down = 1'b0;
  logic rshift_down = 1'b0;
  logic caps_on = 1'b0;

  int   total_bytes = 0;
  int   accepted_bytes = 0;
  int   mismatch_count = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   idle_cycles = 0;
  logic hold_done = 1'b0;
  logic quiet_tail = 1'b0;

  scancode_set1_to_ascii_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scan_code   (in_scan_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] shifted_us(input logic [7:0] ch);
    case (ch)
      "1":     return "!";
      "2":     return "@";
      "3":     return "#";
      "4":     return "$";
      "5":     return "%";
      "6":     return "^";
      "7":     return "&";
      "8":     return "*";
      "9":     return "(";
      "0":     return ")";
      "-":     return "_";
      "=":     return "+";
      "[":     return "{";
      "]":     return "}";
      "\\":    return "|";
      ";":     return ":";
      8'h27:   return 8'h22;
      8'h60:   return "~";
      ",":     return "<";
      ".":     return ">";
      "/":     return "?";
      default: return ch;
    endcase
  endfunction

  // update the shift/caps flags and queue the character this byte yields, if any
  task automatic decode_scan_byte(input logic [7:0] code);
    logic [6:0] key;
    logic       released;
    logic       shift_down;
    logic [7:0] ch;
    key = code[6:0];
    released = code[7];
    if (key == KEY_LSHIFT) begin
      lshift_down = !released;
    end else if (key == KEY_RSHIFT) begin
      rshift_down = !released;
    end else if (!released && code < TABLE_LEN) begin
      if (code == CODE_CAPS) begin
        caps_on = !caps_on;
      end else begin
        ch = KEYMAP[code[6:0]];
        shift_down = lshift_down || rshift_down;
        if (ch >= "a" && ch <= "z") begin
          if (caps_on != shift_down) ch = ch - LETTER_GAP;
        end else if (shift_down) begin
          ch = shifted_us(ch);
        end
        if (ch != 8'h00) expected_chars.push_back(ch[6:0]);
      end
    end
  endtask

  task automatic queue_code(input logic [7:0] code);
    pending_codes.push_back(code);
  endtask

  task automatic flag_mismatch(input string what, input ascii_t want, input ascii_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch (%s): expected 0x%02h, got 0x%02h", what, want, got);
  endtask

  // sender: holds a stalled byte, otherwise idles in bursts or offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_scan_byte(in_scan_code);
        accepted_bytes++;
      end
      if (!(in_valid && in_stall)) begin
        if (!quiet_tail && tx_gap == 0 && $urandom_range(0, 9) == 0)
          tx_gap = $urandom_range(1, 17);
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_codes.size() != 0) begin
          in_valid <= 1'b1;
          in_scan_code <= pending_codes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      quiet_tail <= (pending_codes.size() < TAIL_LEN);
    end
  end

  // receiver: random stall bursts plus one long hold so the input side backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && accepted_bytes >= HOLD_AT) begin
        hold_done = 1'b1;
        rx_gap = LONG_HOLD;
      end else if (quiet_tail) begin
        rx_gap = 0;
      end else if (rx_gap == 0 && $urandom_range(0, 11) == 0) begin
        rx_gap = $urandom_range(1, 17);
      end
      out_stall <= (rx_gap != 0);
      if (rx_gap != 0) rx_gap--;
    end
  end

  always @(posedge clk) begin : result_check
    ascii_t want_char;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        flag_mismatch("no character pending", 7'h00, out_ascii_char);
      end else begin
        want_char = expected_chars.pop_front();
        if (out_ascii_char !== want_char)
          flag_mismatch("ascii_char", want_char, out_ascii_char);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int         make_count;
    int         pick;
    int         n;
    logic [7:0] k;
    logic [7:0] s;

    // directed: each flag path, ignored bytes, zero table entries and range ends
    queue_code(8'h01);                  // escape
    queue_code(8'h1E);                  // plain letter
    queue_code(8'h00);                  // zero entry at code 0
    queue_code({1'b0, KEY_LSHIFT});
    queue_code(8'h1E);                  // shifted letter
    queue_code(8'h02);                  // shifted digit
    queue_code(8'h29);                  // backtick turns into tilde
    queue_code(8'h47);                  // keypad digit under shift
    queue_code({1'b0, KEY_LSHIFT} | BREAK_BIT);
    queue_code(CODE_CAPS);
    queue_code(CODE_CAPS | BREAK_BIT);  // caps release is ignored
    queue_code(8'h1E);                  // caps letter
    queue_code(8'h0C);                  // caps leaves symbols alone
    queue_code({1'b0, KEY_RSHIFT});
    queue_code(8'h1E);                  // caps and shift cancel
    queue_code(8'h2B);                  // backslash to pipe
    queue_code({1'b0, KEY_RSHIFT} | BREAK_BIT);
    queue_code(CODE_CAPS);
    queue_code(8'h1D);                  // ctrl has no character
    queue_code(8'h53);                  // last table entry
    queue_code(8'h54);                  // first code past the table
    queue_code(8'h7F);
    queue_code(EXT_PREFIX);
    queue_code(8'hFF);
    queue_code(8'h39);                  // space

    // random typing: mostly well-formed make/break sequences, some noise
    make_count = 0;
    while (make_count < RANDOM_MAKES) begin
      pick = $urandom_range(0, 99);
      k = 8'($urandom_range(0, TABLE_LEN - 1));
      if (pick < 45) begin
        queue_code(k);
        queue_code(k | BREAK_BIT);
        make_count++;
      end else if (pick < 65) begin
        s = $urandom_range(0, 1) ? {1'b0, KEY_LSHIFT} : {1'b0, KEY_RSHIFT};
        queue_code(s);
        n = $urandom_range(1, 4);
        repeat (n) begin
          k = 8'($urandom_range(0, TABLE_LEN - 1));
          queue_code(k);
          queue_code(k | BREAK_BIT);
          make_count++;
        end
        queue_code(s | BREAK_BIT);
      end else if (pick < 72) begin
        queue_code(CODE_CAPS);
        queue_code(CODE_CAPS | BREAK_BIT);
        make_count++;
      end else if (pick < 80) begin
        queue_code(EXT_PREFIX);
        queue_code(k);
        queue_code(EXT_PREFIX);
        queue_code(k | BREAK_BIT);
        make_count++;
      end else if (pick < 88) begin
        queue_code(8'($urandom_range(TABLE_LEN, 127)));
        make_count++;
      end else begin
        k = 8'($urandom_range(0, 255));
        queue_code(k);
        if (!k[7]) make_count++;
      end
    end
    total_bytes = pending_codes.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_bytes != total_bytes) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### scancode_set1_to_ascii_unit.f
sv/s2a_pkg.sv
sv/s2a_decode.sv
sv/s2a_key_state.sv
sv/scancode_set1_to_ascii_unit.sv
tb/scancode_set1_to_ascii_unit_tb.sv
